/* sv/bmrf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bmrf_pkg;

  localparam int MAX_BITS  = 65536;
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = $clog2(NUM_WORDS);
  localparam int BPOS_W    = $clog2(WORD_BITS);
  localparam int SIZE_W    = 17;
  localparam int INDEX_W   = 16;

  localparam logic [1:0] REQ_SET  = 2'd0;
  localparam logic [1:0] REQ_TEST = 2'd1;
  localparam logic [1:0] REQ_FIND = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [INDEX_W-1:0] bit_index;
    logic [SIZE_W-1:0]  bit_count;
    logic               set_value;
  } req_t;

  typedef struct packed {
    logic              status;
    logic              bit_value;
    logic [SIZE_W-1:0] free_index;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SET_RD,
    ST_SET_WR,
    ST_TEST_CHK,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* sv/bmrf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module bmrf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/bitmap_range_set_test_find_free_core.sv */
// flow: set range decodes, then reads and writes each word touched; find free decodes,
//   then reads and checks each word scanned; test decodes, then checks; out of bounds,
//   zero count, index at or past size, or unused request go from decode to done; one
//   request at a time, the next accepted in idle once the result issues, later while a
//   stalled result still holds the output register; reset: synchronous, a clearing pass
//   writes all 1024 words to zero before the first word is accepted, size resets to 65536
`timescale 1ns / 1ps
`default_nettype none

module bitmap_range_set_test_find_free_core
  import bmrf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire req_t              req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output rsp_t                   rsp,
  input  wire logic              cfg_wr_en,
  input  wire logic [SIZE_W-1:0] cfg_wr_data
);

  localparam int GRP_BITS = 8;
  localparam int NUM_GRP  = WORD_BITS / GRP_BITS;
  localparam int GRP_W    = $clog2(NUM_GRP);
  localparam int GBIT_W   = $clog2(GRP_BITS);
  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

  // first set-bit search in two levels of small priority encoders, lowest index wins;
  function automatic logic [BPOS_W:0] find_first(input logic [WORD_BITS-1:0] v);
    logic [NUM_GRP-1:0]  any;
    logic [GRP_W-1:0]    g;
    logic [GBIT_W-1:0]   b;
    logic [GRP_BITS-1:0] grp;
    any = '0;
    g   = '0;
    b   = '0;
    for (int i = 0; i < NUM_GRP; i++) begin
      any[i] = |v[i*GRP_BITS +: GRP_BITS];
    end
    for (int i = NUM_GRP - 1; i >= 0; i--) begin
      if (any[i]) begin
        g = GRP_W'(i);
      end
    end
    grp = v[g*GRP_BITS +: GRP_BITS];
    for (int i = GRP_BITS - 1; i >= 0; i--) begin
      if (grp[i]) begin
        b = GBIT_W'(i);
      end
    end
    return {|any, g, b};
  endfunction

  state_t               state, state_next;
  logic [WADDR_W-1:0]   clr_addr, clr_addr_next;
  logic [SIZE_W-1:0]    bitmap_size;
  req_t                 req_q;
  logic [WADDR_W-1:0]   word, word_next;
  logic [INDEX_W-1:0]   end_idx, end_idx_next;
  rsp_t                 res, res_next;
  logic                 rsp_valid_next;
  rsp_t                 rsp_next;

  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WADDR_W-1:0]   ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [SIZE_W-1:0]    size_eff;
  logic [SIZE_W:0]      range_end;
  logic [BPOS_W-1:0]    lo_bit, hi_bit;
  logic [WORD_BITS-1:0] wmask, lim, free_bits;
  logic [BPOS_W:0]      ff;
  logic [WADDR_W:0]     word_inc;

  assign size_eff  = (bitmap_size > SIZE_W'(MAX_BITS)) ? SIZE_W'(MAX_BITS) : bitmap_size;
  assign range_end = {2'b00, req_q.bit_index} + {1'b0, req_q.bit_count};
  assign word_inc  = {1'b0, word} + 1'b1;

  assign lo_bit = (word == req_q.bit_index[INDEX_W-1:BPOS_W]) ?
                  req_q.bit_index[BPOS_W-1:0] : '0;
  assign hi_bit = (word == end_idx[INDEX_W-1:BPOS_W]) ? end_idx[BPOS_W-1:0] : '1;
  assign wmask  = (ONES << lo_bit) & (ONES >> (BPOS_W'(WORD_BITS - 1) - hi_bit));

  assign lim       = ({1'b0, word} == size_eff[SIZE_W-1:BPOS_W]) ?
                     ~(ONES << size_eff[BPOS_W-1:0]) : ONES;
  assign free_bits = ~ram_rdata & lim;
  assign ff        = find_first(free_bits);

  assign req_stall = (state != ST_IDLE);

  bmrf_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NUM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      rsp_valid   <= 1'b0;
      bitmap_size <= SIZE_W'(MAX_BITS);
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      rsp_valid <= rsp_valid_next;
      if (cfg_wr_en) begin
        bitmap_size <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
    word    <= word_next;
    end_idx <= end_idx_next;
    res     <= res_next;
    rsp     <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    word_next      = word;
    end_idx_next   = end_idx;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    ram_we         = 1'b0;
    ram_waddr      = word;
    ram_wdata      = '0;
    ram_raddr      = word;

    unique case (state)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        res_next   = '0;
        state_next = ST_DONE;
        unique case (req_q.req_type)
          REQ_SET: begin
            word_next    = req_q.bit_index[INDEX_W-1:BPOS_W];
            end_idx_next = INDEX_W'(range_end - 1'b1);
            if (range_end > {1'b0, size_eff}) begin
              res_next.status = 1'b1;
            end else if (req_q.bit_count != '0) begin
              state_next = ST_SET_RD;
            end
          end
          REQ_TEST: begin
            ram_raddr = req_q.bit_index[INDEX_W-1:BPOS_W];
            if ({1'b0, req_q.bit_index} < size_eff) begin
              state_next = ST_TEST_CHK;
            end
          end
          REQ_FIND: begin
            res_next.free_index = size_eff;
            word_next           = req_q.bit_index[INDEX_W-1:BPOS_W];
            if ({1'b0, req_q.bit_index} < size_eff) begin
              state_next = ST_FIND_RD;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SET_RD: begin
        state_next = ST_SET_WR;
      end
      ST_SET_WR: begin
        ram_we    = 1'b1;
        ram_wdata = req_q.set_value ? (ram_rdata | wmask) : (ram_rdata & ~wmask);
        if (word == end_idx[INDEX_W-1:BPOS_W]) begin
          state_next = ST_DONE;
        end else begin
          word_next  = word_inc[WADDR_W-1:0];
          state_next = ST_SET_RD;
        end
      end
      ST_TEST_CHK: begin
        res_next.bit_value = ram_rdata[req_q.bit_index[BPOS_W-1:0]];
        state_next         = ST_DONE;
      end
      ST_FIND_RD: begin
        state_next = ST_FIND_CHK;
      end
      ST_FIND_CHK: begin
        if (ff[BPOS_W]) begin
          res_next.free_index = {1'b0, word, ff[BPOS_W-1:0]};
          state_next          = ST_DONE;
        end else if ({word_inc, {BPOS_W{1'b0}}} >= size_eff) begin
          state_next = ST_DONE;
        end else begin
          word_next  = word_inc[WADDR_W-1:0];
          state_next = ST_FIND_RD;
        end
      end
      ST_DONE: begin
        // hold the result until the output word is free
        if (!rsp_valid || !rsp_stall) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sim/tb_bitmap_range_set_test_find_free_core.sv */
`timescale 1ns / 1ps

class bitmap_tracker;
  localparam int unsigned WB = bmrf_pkg::WORD_BITS;

  bit [WB-1:0] words [bmrf_pkg::NUM_WORDS];
  int unsigned size_reg;
  bmrf_pkg::rsp_t pending [$];
  int errors;

  function new();
    size_reg = bmrf_pkg::MAX_BITS;
    errors = 0;
  endfunction

  // size in use, clipped to capacity
  function int unsigned span();
    int unsigned cap;
    cap = bmrf_pkg::MAX_BITS;
    return (size_reg > cap) ? cap : size_reg;
  endfunction

  function void note_req(bmrf_pkg::req_t r);
    bmrf_pkg::rsp_t e;
    int unsigned sz, idx, cnt, k, hit;
    e = '0;
    sz = span();
    idx = 32'(r.bit_index);
    cnt = 32'(r.bit_count);
    case (r.req_type)
      bmrf_pkg::REQ_SET: begin
        if (idx + cnt > sz) begin
          e.status = 1'b1;
        end else begin
          for (k = idx; k < idx + cnt; k++) words[k / WB][k % WB] = r.set_value;
        end
      end
      bmrf_pkg::REQ_TEST: begin
        if (idx < sz) e.bit_value = words[idx / WB][idx % WB];
      end
      bmrf_pkg::REQ_FIND: begin
        hit = sz;
        // scan starts at the word boundary below the index
        if (idx < sz) begin
          for (k = idx - idx % WB; k < sz && hit == sz; k++) begin
            if (words[k / WB][k % WB] == 1'b0) hit = k;
          end
        end
        e.free_index = hit[bmrf_pkg::SIZE_W-1:0];
      end
      default: ;
    endcase
    pending.push_back(e);
  endfunction

  function void check_rsp(bmrf_pkg::rsp_t got);
    bmrf_pkg::rsp_t e;
    if (pending.size() == 0) begin
      $error("response word %h with nothing pending", got);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.status !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, got.status);
      errors++;
    end
    if (got.bit_value !== e.bit_value) begin
      $error("bit_value: expected %0d, actual %0d", e.bit_value, got.bit_value);
      errors++;
    end
    if (got.free_index !== e.free_index) begin
      $error("free_index: expected %0d, actual %0d", e.free_index, got.free_index);
      errors++;
    end
  endfunction
endclass

module tb_bitmap_range_set_test_find_free_core;
  import bmrf_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 12000000;
  localparam int NUM_PHASES = 13;
  localparam int RANDOM_PER_PHASE = 81;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  req_t req = '0;
  logic rsp_stall = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data = '0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  bitmap_tracker tracker;
  bit quiet = 1'b0;
  int holdoff_asked = 0;
  int holdoff_seen = 0;
  int hold_left = 0;
  int unsigned cycles = 0;
  int unsigned phase_sizes [NUM_PHASES] =
    '{0, 1, 63, 64, 65, 130, 1000, 4096, 65536, 131071, 65537, 500, 128};

  bitmap_range_set_test_find_free_core dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) tracker.check_rsp(rsp);
  end

  // response side: random stalls, quiet stretch, long hold-off on request
  always @(posedge clk) begin
    if (holdoff_seen != holdoff_asked) begin
      holdoff_seen = holdoff_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (quiet) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < 10);
    end
  end

  function automatic req_t req_word(logic [1:0] kind, int unsigned idx, int unsigned cnt,
                                    bit val);
    req_t r;
    r.req_type = kind;
    r.bit_index = idx[INDEX_W-1:0];
    r.bit_count = cnt[SIZE_W-1:0];
    r.set_value = val;
    return r;
  endfunction

  function automatic req_t rand_req(int unsigned sz);
    int unsigned pick, idx, room, c, cnt;
    logic [1:0] kind;
    pick = $urandom_range(99);
    if (sz == 0 || $urandom_range(9) == 0) begin
      idx = $urandom_range(65535);
    end else if ($urandom_range(9) == 0) begin
      idx = sz - 1 - $urandom_range((sz > 4) ? 3 : sz - 1);
    end else begin
      idx = $urandom_range(sz - 1);
    end
    room = (idx < sz) ? sz - idx : 0;
    cnt = $urandom_range(131071);
    if (pick < 3) begin
      kind = REQ_UNUSED;
    end else if (pick < 40) begin
      kind = REQ_SET;
      c = $urandom_range(99);
      if (c < 55) begin
        cnt = $urandom_range((room < 80) ? room : 80);
      end else if (c < 70) begin
        cnt = (room <= 1024) ? room : $urandom_range(64);
      end else if (c < 82) begin
        cnt = room + 1;
      end else if (c < 94) begin
        cnt = $urandom_range(1000);
      end else if (c >= 98) begin
        // whole bitmap in one go
        idx = 0;
        cnt = sz;
      end
    end else if (pick < 70) begin
      kind = REQ_TEST;
    end else begin
      kind = REQ_FIND;
    end
    return req_word(kind, idx, cnt, $urandom_range(99) < 60);
  endfunction

  task automatic send_word(input req_t r);
    if (!quiet && $urandom_range(99) < 10) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    tracker.note_req(r);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size(input int unsigned v);
    cfg_wr_data <= v[SIZE_W-1:0];
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.size_reg = v;
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_word(req_word(REQ_TEST, 0, 0, 1'b0));
    send_word(req_word(REQ_FIND, 0, 0, 1'b0));
    send_word(req_word(REQ_SET, 0, 0, 1'b1));
    send_word(req_word(REQ_SET, 0, 70, 1'b1));
    send_word(req_word(REQ_FIND, 5, 0, 1'b0));
    send_word(req_word(REQ_TEST, 69, 0, 1'b0));
    send_word(req_word(REQ_TEST, 70, 0, 1'b0));
    send_word(req_word(REQ_SET, 65535, 1, 1'b1));
    send_word(req_word(REQ_TEST, 65535, 0, 1'b0));
    send_word(req_word(REQ_SET, 65535, 2, 1'b1));
    // fill everything, then search a full bitmap
    send_word(req_word(REQ_SET, 0, 65536, 1'b1));
    send_word(req_word(REQ_FIND, 0, 0, 1'b0));
    send_word(req_word(REQ_FIND, 65535, 0, 1'b0));
    // hole below the start index in the same word
    send_word(req_word(REQ_SET, 100, 1, 1'b0));
    send_word(req_word(REQ_FIND, 127, 0, 1'b0));
    send_word(req_word(REQ_TEST, 100, 0, 1'b1));
    send_word(req_word(REQ_SET, 0, 131071, 1'b0));
    send_word(req_word(REQ_SET, 0, 65536, 1'b0));
    send_word(req_word(REQ_UNUSED, 65535, 131071, 1'b1));
    send_word(req_word(REQ_TEST, 65535, 0, 1'b0));
    send_word(req_word(REQ_FIND, 65535, 0, 1'b0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      quiet = (p == 7);
      write_size(phase_sizes[p]);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (p == 8 && i == 10) holdoff_asked++;
        if (p == 3 && i == 40) settle();
        send_word(rand_req(tracker.span()));
      end
    end
    settle();

    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
sv/bmrf_pkg.sv
sv/bmrf_ram.sv
sv/bitmap_range_set_test_find_free_core.sv
sim/tb_bitmap_range_set_test_find_free_core.sv
